// ===== rtl/d2pc_pkg.sv =====
package d2pc_pkg;

  // frame limits
  localparam int FRAME_WIDTH_MAX  = 4096;
  localparam int FRAME_HEIGHT_MAX = 4096;

  // field widths
  localparam int DEPTH_W  = 16;
  localparam int PIX_W    = 12;
  localparam int CENTER_W = 16;
  localparam int RECIP_W  = 24;
  localparam int DSCALE_W = 17;
  localparam int Z_W      = 24;
  localparam int COORD_W  = 32;

  // derived arithmetic widths
  localparam int ZPROD_W = DEPTH_W + DSCALE_W;
  localparam int P_W     = CENTER_W + Z_W;
  localparam int PLO_W   = 20;
  localparam int PHI_W   = P_W - PLO_W;
  localparam int PP_W    = PLO_W + RECIP_W;
  localparam int R_W     = PP_W + 1 - 8;

  // pipeline depth, output register included
  localparam int NSTAGE = 6;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DEPTH_W-1:0] NO_MEASUREMENT = '1;
  localparam logic [Z_W-1:0]     Z_MAX          = '1;

  // register reset values
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd3840;
  localparam logic [RECIP_W-1:0]  FOCAL_X_RST  = 24'd33554;
  localparam logic [RECIP_W-1:0]  FOCAL_Y_RST  = 24'd33554;
  localparam logic [DSCALE_W-1:0] DSCALE_RST   = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_FOCAL_X_RCP  = 3'd2,
    REG_FOCAL_Y_RCP  = 3'd3,
    REG_DEPTH_SCALE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RECIP_W-1:0]  focal_x_recip;
    logic [RECIP_W-1:0]  focal_y_recip;
    logic [DSCALE_W-1:0] depth_scale_recip;
  } cfg_t;

  // per-stage load enables, bit k loads stage k+1
  typedef struct packed {
    logic [NSTAGE-1:0] adv;
  } pipe_ctl_t;

endpackage

// ===== rtl/depth_to_point_cloud.sv =====
// channel   dir  handshake          payload
// in_       in   tvalid / tready    tdata: depth_code, pixel_column, pixel_row
// out_      out  tvalid / tready    tdata: point_x, point_y, point_z; tuser: point_invalid
// cfg_      in   we (no wait)       index, wdata
//
// one item per cycle sustained while out_tready is high; each item passes through the
// six register stages of the projection multiplier chain, output register included
// reset (rst_n low at a clock edge) empties the pipeline and loads default registers
// each stage loads when it is empty or the stage after it moves; in_tready falls
// only when every stage holds an item and out_tready is low
module depth_to_point_cloud (
  input  logic                             clk,
  input  logic                             rst_n,
  // depth_code [15:0], pixel_column [27:16], pixel_row [39:28]
  input  logic [39:0]                      in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // point_x [31:0], point_y [63:32], point_z [87:64]
  output logic [87:0]                      out_tdata,
  // point_invalid [0]
  output logic [0:0]                       out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [d2pc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [d2pc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int N = d2pc_pkg::NSTAGE;

  d2pc_pkg::cfg_t      cfg;
  d2pc_pkg::pipe_ctl_t ctl;

  logic [d2pc_pkg::DEPTH_W-1:0] depth_code;
  logic [d2pc_pkg::PIX_W-1:0]   col_raw;
  logic [d2pc_pkg::PIX_W-1:0]   row_raw;
  logic [d2pc_pkg::PIX_W-1:0]   col;
  logic [d2pc_pkg::PIX_W-1:0]   row;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] inv_r;
  logic [N-1:0] inv_nxt;
  logic [N-1:0] rdy;

  logic signed [d2pc_pkg::COORD_W-1:0] point_x;
  logic signed [d2pc_pkg::COORD_W-1:0] point_y;
  logic [d2pc_pkg::Z_W-1:0]            z_s2;
  logic [d2pc_pkg::Z_W-1:0]            point_z;

  // unpack input item and clamp indexes to the frame
  always_comb begin
    depth_code = in_tdata[15:0];
    col_raw    = in_tdata[27:16];
    row_raw    = in_tdata[39:28];
    col = ((d2pc_pkg::PIX_W+1)'(col_raw) >= (d2pc_pkg::PIX_W+1)'(d2pc_pkg::FRAME_WIDTH_MAX))
        ? d2pc_pkg::PIX_W'(d2pc_pkg::FRAME_WIDTH_MAX - 1) : col_raw;
    row = ((d2pc_pkg::PIX_W+1)'(row_raw) >= (d2pc_pkg::PIX_W+1)'(d2pc_pkg::FRAME_HEIGHT_MAX))
        ? d2pc_pkg::PIX_W'(d2pc_pkg::FRAME_HEIGHT_MAX - 1) : row_raw;
  end

  // stage ready chain from the output back
  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_tready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ctl.adv = rdy;
  end

  assign in_tready = rdy[0];

  // valid and no-measurement flags travel with the data
  assign v_nxt   = {v_r[N-2:0], in_tvalid};
  assign inv_nxt = {inv_r[N-2:0], depth_code == d2pc_pkg::NO_MEASUREMENT};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k]) begin
        inv_r[k] <= inv_nxt[k];
      end
    end
  end

  d2pc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  d2pc_depth u_depth (
    .clk               (clk),
    .ctl               (ctl),
    .depth_code        (depth_code),
    .depth_scale_recip (cfg.depth_scale_recip),
    .invalid_s1        (inv_r[0]),
    .z_s2              (z_s2),
    .z_out             (point_z)
  );

  d2pc_proj u_proj_x (
    .clk    (clk),
    .ctl    (ctl),
    .pix    (col),
    .center (cfg.center_x),
    .recip  (cfg.focal_x_recip),
    .z_s2   (z_s2),
    .coord  (point_x)
  );

  d2pc_proj u_proj_y (
    .clk    (clk),
    .ctl    (ctl),
    .pix    (row),
    .center (cfg.center_y),
    .recip  (cfg.focal_y_recip),
    .z_s2   (z_s2),
    .coord  (point_y)
  );

  // result item
  assign out_tvalid   = v_r[N-1];
  assign out_tuser[0] = inv_r[N-1];
  assign out_tdata    = {point_z, point_y, point_x};

endmodule

// ===== rtl/d2pc_cfg.sv =====
module d2pc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [d2pc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [d2pc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output d2pc_pkg::cfg_t                   cfg
);

  d2pc_pkg::cfg_t cfg_r;

  // register file, writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x          <= d2pc_pkg::CENTER_X_RST;
      cfg_r.center_y          <= d2pc_pkg::CENTER_Y_RST;
      cfg_r.focal_x_recip     <= d2pc_pkg::FOCAL_X_RST;
      cfg_r.focal_y_recip     <= d2pc_pkg::FOCAL_Y_RST;
      cfg_r.depth_scale_recip <= d2pc_pkg::DSCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        d2pc_pkg::REG_CENTER_X:
          cfg_r.center_x <= cfg_wdata[d2pc_pkg::CENTER_W-1:0];
        d2pc_pkg::REG_CENTER_Y:
          cfg_r.center_y <= cfg_wdata[d2pc_pkg::CENTER_W-1:0];
        d2pc_pkg::REG_FOCAL_X_RCP:
          cfg_r.focal_x_recip <= cfg_wdata[d2pc_pkg::RECIP_W-1:0];
        d2pc_pkg::REG_FOCAL_Y_RCP:
          cfg_r.focal_y_recip <= cfg_wdata[d2pc_pkg::RECIP_W-1:0];
        d2pc_pkg::REG_DEPTH_SCALE:
          cfg_r.depth_scale_recip <= cfg_wdata[d2pc_pkg::DSCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/d2pc_depth.sv =====
module d2pc_depth (
  input  logic                            clk,
  input  d2pc_pkg::pipe_ctl_t             ctl,
  input  logic [d2pc_pkg::DEPTH_W-1:0]    depth_code,
  input  logic [d2pc_pkg::DSCALE_W-1:0]   depth_scale_recip,
  input  logic                            invalid_s1,
  output logic [d2pc_pkg::Z_W-1:0]        z_s2,
  output logic [d2pc_pkg::Z_W-1:0]        z_out
);

  logic [d2pc_pkg::ZPROD_W-1:0]   zprod_r;
  logic [d2pc_pkg::ZPROD_W:0]     zsum;
  logic [d2pc_pkg::ZPROD_W-8:0]   zq;
  logic [d2pc_pkg::Z_W-1:0]       z_nxt;
  logic [d2pc_pkg::Z_W-1:0]       z_r [1:d2pc_pkg::NSTAGE-1];

  // stage 1: raw product of code and scale
  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      zprod_r <= d2pc_pkg::ZPROD_W'(depth_code) * d2pc_pkg::ZPROD_W'(depth_scale_recip);
    end
  end

  // stage 2: round half up to q.8, saturate, zero for no measurement
  always_comb begin
    zsum = (d2pc_pkg::ZPROD_W+1)'(zprod_r) + (d2pc_pkg::ZPROD_W+1)'(128);
    zq   = zsum[d2pc_pkg::ZPROD_W:8];
    if (invalid_s1) begin
      z_nxt = '0;
    end else if (zq > (d2pc_pkg::ZPROD_W-7)'(d2pc_pkg::Z_MAX)) begin
      z_nxt = d2pc_pkg::Z_MAX;
    end else begin
      z_nxt = zq[d2pc_pkg::Z_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      z_r[1] <= z_nxt;
    end
  end

  // delay line up to the output stage
  for (genvar k = 2; k < d2pc_pkg::NSTAGE; k++) begin : g_zdly
    always_ff @(posedge clk) begin
      if (ctl.adv[k]) begin
        z_r[k] <= z_r[k-1];
      end
    end
  end

  assign z_s2  = z_r[1];
  assign z_out = z_r[d2pc_pkg::NSTAGE-1];

endmodule

// ===== rtl/d2pc_proj.sv =====
module d2pc_proj (
  input  logic                                  clk,
  input  d2pc_pkg::pipe_ctl_t                   ctl,
  input  logic [d2pc_pkg::PIX_W-1:0]            pix,
  input  logic [d2pc_pkg::CENTER_W-1:0]         center,
  input  logic [d2pc_pkg::RECIP_W-1:0]          recip,
  input  logic [d2pc_pkg::Z_W-1:0]              z_s2,
  output logic signed [d2pc_pkg::COORD_W-1:0]   coord
);

  localparam logic [d2pc_pkg::R_W-1:0] POS_MAX = d2pc_pkg::R_W'({1'b0, {(d2pc_pkg::COORD_W-1){1'b1}}});
  localparam logic [d2pc_pkg::R_W-1:0] NEG_MAG = d2pc_pkg::R_W'({1'b1, {(d2pc_pkg::COORD_W-1){1'b0}}});

  logic [d2pc_pkg::CENTER_W-1:0] a;
  logic                          neg_nxt;
  logic [d2pc_pkg::CENTER_W-1:0] mag_nxt;
  logic [d2pc_pkg::CENTER_W-1:0] mag_r;
  logic [d2pc_pkg::CENTER_W-1:0] mag2_r;
  logic                          neg_r [0:4];
  logic [d2pc_pkg::P_W-1:0]      p_r;
  logic [d2pc_pkg::PP_W-1:0]     hp_r;
  logic [d2pc_pkg::PP_W-1:0]     lp_r;
  logic [d2pc_pkg::PP_W:0]       lrnd;
  logic [d2pc_pkg::PP_W:0]       rsum;
  logic [d2pc_pkg::R_W-1:0]      r_r;
  logic [d2pc_pkg::COORD_W-1:0]  coord_nxt;
  logic [d2pc_pkg::COORD_W-1:0]  coord_r;

  // stage 1: offset from principal point as sign and magnitude
  always_comb begin
    a       = {pix, 4'b0000};
    neg_nxt = a < center;
    mag_nxt = neg_nxt ? (center - a) : (a - center);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      mag_r    <= mag_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  // sign travels alongside to the output stage
  for (genvar k = 1; k < 5; k++) begin : g_neg
    always_ff @(posedge clk) begin
      if (ctl.adv[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // stage 2: wait for z
  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      mag2_r <= mag_r;
    end
  end

  // stage 3: magnitude times z
  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      p_r <= d2pc_pkg::P_W'(mag2_r) * d2pc_pkg::P_W'(z_s2);
    end
  end

  // stage 4: two partial products with the reciprocal
  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      hp_r <= d2pc_pkg::PP_W'(p_r[d2pc_pkg::P_W-1:d2pc_pkg::PLO_W]) * d2pc_pkg::PP_W'(recip);
      lp_r <= d2pc_pkg::PP_W'(p_r[d2pc_pkg::PLO_W-1:0]) * d2pc_pkg::PP_W'(recip);
    end
  end

  // stage 5: combine partials, round half away from zero to q.8
  always_comb begin
    lrnd = (d2pc_pkg::PP_W+1)'(lp_r) + (d2pc_pkg::PP_W+1)'(64'd1 << 27);
    rsum = (d2pc_pkg::PP_W+1)'(hp_r)
         + (d2pc_pkg::PP_W+1)'(lrnd[d2pc_pkg::PP_W:d2pc_pkg::PLO_W]);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      r_r <= rsum[d2pc_pkg::PP_W:8];
    end
  end

  // stage 6: apply sign and saturate
  always_comb begin
    if (neg_r[4]) begin
      if (r_r >= NEG_MAG) begin
        coord_nxt = NEG_MAG[d2pc_pkg::COORD_W-1:0];
      end else begin
        coord_nxt = '0 - r_r[d2pc_pkg::COORD_W-1:0];
      end
    end else if (r_r > POS_MAX) begin
      coord_nxt = POS_MAX[d2pc_pkg::COORD_W-1:0];
    end else begin
      coord_nxt = r_r[d2pc_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[5]) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = signed'(coord_r);

endmodule

// ===== rtl/d2pc_chk.sv =====
module d2pc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic [87:0]                      out_tdata,
  input logic [0:0]                       out_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  // no-measurement items carry an all-zero point
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("invalid item with nonzero point");

  // zero distance projects to the origin
  a_z_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[87:64] == '0 |-> out_tdata[63:0] == '0)
    else $error("zero z with nonzero x or y");

  // an empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result item right after reset");

endmodule

bind depth_to_point_cloud d2pc_chk u_d2pc_chk (.*);
